// ===== sv/multimode_finder_macros.svh =====
// assertion macros used by the multimode finder sequencer
`ifndef MULTIMODE_FINDER_MACROS_SVH
`define MULTIMODE_FINDER_MACROS_SVH

// same-cycle implication, held off during reset
`define MMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmf assertion failed");

// next-cycle implication, held off during reset
`define MMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmf assertion failed");

`endif

// ===== sv/mmf_pkg.sv =====
// types and constants of the multimode finder
package mmf_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int CNT_W    = 7;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        key_t key_value;
        logic batch_end;
    } key_item_t;

    typedef struct packed {
        key_t mode_key;
        cnt_t mode_freq;
        cnt_t mode_total;
        logic run_last;
        logic overflow;
    } mode_item_t;

    typedef struct packed {
        key_t key;
        cnt_t count;
    } entry_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_rd_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic       valid;
        mode_item_t item;
    } emit_t;

endpackage

// ===== sv/multimode_finder.sv =====
// top level of the multimode finder: sequencer, store and result register
//
//  channel  role    payload      handshake
//  key      in      key_data     key_valid / key_stall
//  mode     out     mode_data    mode_valid / mode_stall
//
//  a matching key is counted after a search from position 0; a new key is searched,
//  the entries above it shift up and it is placed (appended when it sorts last);
//  first or dropped key: at once; a batch end adds a count scan and an emission scan
//  held by mode_stall; no clearing pass after reset, only filled entries read
//  a result in the output register blocks emission only while mode_stall is high
module multimode_finder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  mmf_pkg::key_item_t   key_data,
    output logic                 mode_valid,
    input  logic                 mode_stall,
    output mmf_pkg::mode_item_t  mode_data
);
    import mmf_pkg::*;

    mem_rd_t    rd;
    mem_wr_t    wr;
    entry_t     rd_data;
    emit_t      emit;
    logic       out_free;
    logic       mode_valid_reg;
    mode_item_t mode_data_reg;

    assign out_free = !mode_valid_reg || !mode_stall;

    mmf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_data  (key_data),
        .out_free  (out_free),
        .emit      (emit),
        .rd        (rd),
        .wr        (wr),
        .rd_data   (rd_data)
    );

    mmf_store u_store (
        .clk     (clk),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            mode_valid_reg <= 1'b1;
        end
        else if (!mode_stall)
        begin
            mode_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            mode_data_reg <= emit.item;
        end
    end

    assign mode_valid = mode_valid_reg;
    assign mode_data  = mode_data_reg;

endmodule

// ===== sv/mmf_store.sv =====
// key and count store: one write port, one registered read port
module mmf_store (
    input  logic            clk,
    input  mmf_pkg::mem_rd_t rd,
    input  mmf_pkg::mem_wr_t wr,
    output mmf_pkg::entry_t  rd_data
);
    import mmf_pkg::*;

    entry_t store_mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= store_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mmf_seq.sv =====
// sequencer: sorted insert, maximum scan and emission over the store
`include "multimode_finder_macros.svh"

module mmf_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  mmf_pkg::key_item_t   key_data,
    input  logic                 out_free,
    output mmf_pkg::emit_t       emit,
    output mmf_pkg::mem_rd_t     rd,
    output mmf_pkg::mem_wr_t     wr,
    input  mmf_pkg::entry_t      rd_data
);
    import mmf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEARCH = 7'b0000010,
        ST_SHIFT  = 7'b0000100,
        ST_PLACE  = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_MAX    = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    addr_t  idx_reg, idx_next;
    addr_t  pos_reg, pos_next;
    key_t   key_reg, key_next;
    logic   end_reg, end_next;
    cnt_t   used_reg, used_next;
    cnt_t   taken_reg, taken_next;
    logic   dropped_reg, dropped_next;
    cnt_t   best_reg, best_next;
    cnt_t   ties_reg, ties_next;
    cnt_t   emitted_reg, emitted_next;
    logic   finish;
    addr_t  idx_up;
    cnt_t   idx_up_cnt;
    addr_t  used_top;

    assign idx_up     = idx_reg + addr_t'(1);
    assign idx_up_cnt = cnt_t'(idx_reg) + cnt_t'(1);
    assign used_top   = addr_t'(used_reg - cnt_t'(1));
    assign key_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        end_next     = end_reg;
        used_next    = used_reg;
        taken_next   = taken_reg;
        dropped_next = dropped_reg;
        best_next    = best_reg;
        ties_next    = ties_reg;
        emitted_next = emitted_reg;
        finish       = 1'b0;
        rd           = '{en: 1'b0, addr: idx_reg};
        wr           = '{en: 1'b0, addr: idx_reg, data: rd_data};
        emit.valid   = 1'b0;
        emit.item    = '{mode_key:   rd_data.key,
                         mode_freq:  best_reg,
                         mode_total: ties_reg,
                         run_last:   (emitted_reg + cnt_t'(1)) == ties_reg,
                         overflow:   dropped_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    key_next = key_data.key_value;
                    end_next = key_data.batch_end;
                    if (taken_reg >= cnt_t'(CAPACITY))
                    begin
                        dropped_next = 1'b1;
                        finish       = 1'b1;
                    end
                    else
                    begin
                        taken_next = taken_reg + cnt_t'(1);
                        if (used_reg == '0)
                        begin
                            wr        = '{en: 1'b1, addr: '0,
                                          data: '{key: key_data.key_value, count: cnt_t'(1)}};
                            used_next = cnt_t'(1);
                            finish    = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            rd         = '{en: 1'b1, addr: '0};
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (rd_data.key == key_reg)
                begin
                    wr     = '{en: 1'b1, addr: idx_reg,
                               data: '{key: key_reg, count: rd_data.count + cnt_t'(1)}};
                    finish = 1'b1;
                end
                else if (rd_data.key > key_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = used_top;
                    rd         = '{en: 1'b1, addr: used_top};
                    state_next = ST_SHIFT;
                end
                else if (idx_up_cnt == used_reg)
                begin
                    wr        = '{en: 1'b1, addr: addr_t'(used_reg),
                                  data: '{key: key_reg, count: cnt_t'(1)}};
                    used_next = used_reg + cnt_t'(1);
                    finish    = 1'b1;
                end
                else
                begin
                    idx_next = idx_up;
                    rd       = '{en: 1'b1, addr: idx_up};
                end
            end
            ST_SHIFT:
            begin
                wr = '{en: 1'b1, addr: idx_up, data: rd_data};
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - addr_t'(1);
                    rd       = '{en: 1'b1, addr: idx_reg - addr_t'(1)};
                end
            end
            ST_PLACE:
            begin
                wr        = '{en: 1'b1, addr: pos_reg,
                              data: '{key: key_reg, count: cnt_t'(1)}};
                used_next = used_reg + cnt_t'(1);
                finish    = 1'b1;
            end
            ST_SCAN:
            begin
                idx_next   = '0;
                rd         = '{en: 1'b1, addr: '0};
                best_next  = '0;
                ties_next  = '0;
                state_next = ST_MAX;
            end
            ST_MAX:
            begin
                if (rd_data.count > best_reg)
                begin
                    best_next = rd_data.count;
                    ties_next = cnt_t'(1);
                end
                else if (rd_data.count == best_reg)
                begin
                    ties_next = ties_reg + cnt_t'(1);
                end
                if (idx_up_cnt == used_reg)
                begin
                    idx_next     = '0;
                    rd           = '{en: 1'b1, addr: '0};
                    emitted_next = '0;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_up;
                    rd       = '{en: 1'b1, addr: idx_up};
                end
            end
            ST_EMIT:
            begin
                if (!(rd_data.count == best_reg && !out_free))
                begin
                    if (rd_data.count == best_reg)
                    begin
                        emit.valid   = 1'b1;
                        emitted_next = emitted_reg + cnt_t'(1);
                    end
                    if (idx_up_cnt == used_reg)
                    begin
                        used_next    = '0;
                        taken_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_up;
                        rd       = '{en: 1'b1, addr: idx_up};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = end_next ? ST_SCAN : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            taken_reg   <= '0;
            dropped_reg <= 1'b0;
            emitted_reg <= '0;
            best_reg    <= '0;
            ties_reg    <= '0;
            idx_reg     <= '0;
            pos_reg     <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            taken_reg   <= taken_next;
            dropped_reg <= dropped_next;
            emitted_reg <= emitted_next;
            best_reg    <= best_next;
            ties_reg    <= ties_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            end_reg     <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    `MMF_ASSERT_NOW(a_no_rw_clash, clk, rst_n, wr.en && rd.en, wr.addr != rd.addr)
    `MMF_ASSERT_NOW(a_used_le_taken, clk, rst_n, 1'b1, used_reg <= taken_reg)
    `MMF_ASSERT_NOW(a_emit_into_free, clk, rst_n, emit.valid, out_free)
    `MMF_ASSERT_NOW(a_emit_le_ties, clk, rst_n, state_reg == ST_EMIT, emitted_reg <= ties_reg)
    `MMF_ASSERT_NEXT(a_last_closes, clk, rst_n, emit.valid && emit.item.run_last,
                     emitted_reg == ties_reg)

endmodule

// ===== tb/multimode_finder_test.sv =====
// self-checking testbench of the multimode finder against a sorted-count predictor
module multimode_finder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mmf_pkg::*;

    localparam int ITEM_TARGET  = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       key_valid = 1'b0;
    logic       key_stall;
    key_item_t  key_data = '0;
    logic       mode_valid;
    logic       mode_stall = 1'b0;
    mode_item_t mode_data;

    key_item_t  pending_keys[$];
    mode_item_t expected_modes[$];

    key_t stored_key [CAPACITY];
    cnt_t stored_cnt [CAPACITY];
    int   stored_n = 0;
    int   taken_n = 0;
    logic dropped = 1'b0;

    int keys_sent = 0;
    int hold_left = 0;
    int holds_done = 0;
    int gap_left = 0;
    int stall_left = 0;
    int calm_tx = 0;
    int calm_rx = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int total_items = 0;

    multimode_finder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_data   (key_data),
        .mode_valid (mode_valid),
        .mode_stall (mode_stall),
        .mode_data  (mode_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sorted insert or count, then all modes at the batch end
    task automatic tally_key(input key_item_t it);
        int         pos;
        int         i;
        cnt_t       top;
        int         ties;
        int         emitted;
        mode_item_t m;
        pos = 0;
        if (taken_n >= CAPACITY)
        begin
            dropped = 1'b1;
        end
        else
        begin
            taken_n++;
            while (pos < stored_n && stored_key[pos] < it.key_value)
                pos++;
            if (pos < stored_n && stored_key[pos] == it.key_value)
            begin
                stored_cnt[pos] = stored_cnt[pos] + cnt_t'(1);
            end
            else
            begin
                for (i = stored_n; i > pos; i--)
                begin
                    stored_key[i] = stored_key[i-1];
                    stored_cnt[i] = stored_cnt[i-1];
                end
                stored_key[pos] = it.key_value;
                stored_cnt[pos] = cnt_t'(1);
                stored_n++;
            end
        end
        if (it.batch_end)
        begin
            top = '0;
            ties = 0;
            for (i = 0; i < stored_n; i++)
            begin
                if (stored_cnt[i] > top)
                begin
                    top = stored_cnt[i];
                    ties = 1;
                end
                else if (stored_cnt[i] == top)
                begin
                    ties++;
                end
            end
            emitted = 0;
            for (i = 0; i < stored_n; i++)
            begin
                if (stored_cnt[i] == top && top != '0)
                begin
                    emitted++;
                    m.mode_key   = stored_key[i];
                    m.mode_freq  = top;
                    m.mode_total = cnt_t'(ties);
                    m.run_last   = (emitted == ties);
                    m.overflow   = dropped;
                    expected_modes.push_back(m);
                end
            end
            stored_n = 0;
            taken_n = 0;
            dropped = 1'b0;
        end
    endtask

    function automatic int pause_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic key_t rand_key();
        int   r;
        key_t k;
        r = $urandom_range(9, 0);
        if (r == 0)
            k = '0;
        else if (r == 1)
            k = '1;
        else if (r == 2)
            k = key_t'($urandom_range(15, 0));
        else
            k = {$urandom, $urandom};
        return k;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    task automatic push_key(input key_t k, input logic last);
        key_item_t it;
        it.key_value = k;
        it.batch_end = last;
        pending_keys.push_back(it);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : tx_drive
        int g;
        if (!rst_n)
        begin
            key_valid <= 1'b0;
            key_data  <= '0;
            keys_sent <= 0;
            gap_left = 0;
            calm_tx = 0;
        end
        else
        begin
            if (key_valid && !key_stall)
            begin
                tally_key(key_data);
                keys_sent <= keys_sent + 1;
            end
            if (!key_valid || !key_stall)
            begin
                if (gap_left > 0 && hold_left == 0)
                begin
                    gap_left--;
                    key_valid <= 1'b0;
                end
                else if (pending_keys.size() != 0)
                begin
                    key_data  <= pending_keys.pop_front();
                    key_valid <= 1'b1;
                    if (hold_left > 0 || calm_tx > 0)
                    begin
                        g = 0;
                        if (calm_tx > 0)
                            calm_tx--;
                    end
                    else
                    begin
                        g = pause_len();
                        if ($urandom_range(29, 0) == 0)
                            calm_tx = 25;
                    end
                    gap_left = g;
                end
                else
                begin
                    key_valid <= 1'b0;
                end
            end
        end
    end

    // receiver pacing, with two long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin : rx_pace
        int g;
        if (!rst_n)
        begin
            mode_stall <= 1'b0;
            hold_left  <= 0;
            stall_left = 0;
            calm_rx = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left  <= hold_left - 1;
            mode_stall <= 1'b1;
        end
        else if (holds_done < 2 && keys_sent >= ((holds_done == 0) ? 30 : 220))
        begin
            holds_done = holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            mode_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            mode_stall <= 1'b1;
        end
        else
        begin
            if (calm_rx > 0)
            begin
                calm_rx--;
                g = 0;
            end
            else
            begin
                g = pause_len();
                if ($urandom_range(39, 0) == 0)
                    calm_rx = 30;
            end
            mode_stall <= (g > 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin : rx_check
        mode_item_t want;
        if (rst_n)
        begin
            if ((key_valid && !key_stall) || (mode_valid && !mode_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("multimode_finder verification failed");
                    $finish;
                end
            end
            if (mode_valid && !mode_stall)
            begin
                if (expected_modes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: expected none got key %h freq %0d total %0d last %b ovf %b",
                             $time, mode_data.mode_key, mode_data.mode_freq,
                             mode_data.mode_total, mode_data.run_last, mode_data.overflow);
                end
                else
                begin
                    want = expected_modes.pop_front();
                    check_field("mode_key", want.mode_key, mode_data.mode_key);
                    check_field("mode_freq", 64'(want.mode_freq), 64'(mode_data.mode_freq));
                    check_field("mode_total", 64'(want.mode_total),
                                64'(mode_data.mode_total));
                    check_field("run_last", 64'(want.run_last), 64'(mode_data.run_last));
                    check_field("overflow", 64'(want.overflow), 64'(mode_data.overflow));
                end
            end
        end
    end

    initial
    begin
        key_t pool [8];
        key_t k;
        int   bno;
        int   len;
        int   psize;
        int   i;

        // directed batches
        push_key(64'h0, 1'b1);
        push_key('1, 1'b1);
        push_key(key_t'(5), 1'b0);
        push_key(key_t'(3), 1'b0);
        push_key(key_t'(5), 1'b0);
        push_key(key_t'(3), 1'b0);
        push_key(key_t'(9), 1'b1);
        push_key('1, 1'b0);
        push_key(64'h8000_0000_0000_0000, 1'b0);
        push_key(key_t'(1), 1'b0);
        push_key(64'h0, 1'b1);
        push_key(64'h5555_5555_5555_5555, 1'b0);
        push_key(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        push_key(64'h5555_5555_5555_5555, 1'b0);
        push_key(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        push_key(64'h5555_5555_5555_5555, 1'b1);
        push_key(key_t'(7), 1'b0);
        push_key(key_t'(7), 1'b0);
        push_key(key_t'(1), 1'b1);

        // random batches, a few at full size or beyond capacity
        bno = 0;
        while (pending_keys.size() < ITEM_TARGET)
        begin
            for (i = 0; i < 8; i++)
                pool[i] = (i > 0 && $urandom_range(3, 0) == 0) ? pool[i-1] + key_t'(1)
                                                                : rand_key();
            case (bno)
                2:
                begin
                    k = rand_key();
                    for (i = 0; i < CAPACITY; i++)
                        push_key(k, i == CAPACITY - 1);
                end
                5:
                begin
                    for (i = 0; i < CAPACITY; i++)
                        push_key({$urandom, $urandom}, i == CAPACITY - 1);
                end
                8:
                begin
                    psize = $urandom_range(4, 1);
                    len = $urandom_range(72, 65);
                    for (i = 0; i < len; i++)
                        push_key(pool[$urandom_range(psize - 1, 0)], i == len - 1);
                end
                11:
                begin
                    len = $urandom_range(68, 65);
                    for (i = 0; i < len; i++)
                        push_key({$urandom, $urandom}, i == len - 1);
                end
                default:
                begin
                    len = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 13)
                                                      : $urandom_range(10, 1);
                    psize = $urandom_range(8, 1);
                    for (i = 0; i < len; i++)
                        push_key(pool[$urandom_range(psize - 1, 0)], i == len - 1);
                end
            endcase
            bno++;
        end
        total_items = pending_keys.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (keys_sent != total_items)
            @(negedge clk);
        while (expected_modes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("multimode_finder verification clean");
        else
            $display("multimode_finder verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mmf_pkg.sv
sv/mmf_store.sv
sv/mmf_seq.sv
sv/multimode_finder.sv
tb/multimode_finder_test.sv
